[src/rsos_pkg.sv]
// ----------------------------------------------------------------------------
// rsos_pkg
// Shared types and constants for the range scan object segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsos_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register and result field widths
    localparam int MAX_DIST_W   = 16;
    localparam int MIN_WIDTH_W  = 8;
    localparam int EDGE_TOL_W   = 16;
    localparam int OFFSET_W     = 5;
    localparam int ANGLE_W      = 9;
    localparam int WIDTH_DEG_W  = 8;
    localparam int OBJ_DIST_W   = 16;
    localparam int OBJ_INDEX_W  = 7;
    localparam int INDEX_W      = 8;
    localparam int M_TDATA_W    = ANGLE_W + WIDTH_DEG_W + OBJ_DIST_W + OBJ_INDEX_W;

    // Sweep geometry in degrees
    localparam int SWEEP_DEG = 180;
    localparam int EDGE_DEG  = 2;

    // Register reset values
    localparam logic [MAX_DIST_W-1:0]  MAX_DIST_RST  = 16'hFFFF;
    localparam logic [MIN_WIDTH_W-1:0] MIN_WIDTH_RST = 8'd0;
    localparam logic [EDGE_TOL_W-1:0]  EDGE_TOL_RST  = 16'd160;
    localparam logic [OFFSET_W-1:0]    OFFSET_RST    = 5'b11011;

    localparam logic [OBJ_INDEX_W-1:0] OBJ_INDEX_MAX = 7'd127;
    localparam logic [INDEX_W-1:0]     INDEX_MAX     = 8'd255;
    localparam logic [WIDTH_DEG_W-1:0] WIDTH_DEG_MAX = 8'd255;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_MAX_DISTANCE = 2'd0,
        REG_MIN_WIDTH    = 2'd1,
        REG_EDGE_TOL     = 2'd2,
        REG_ANGLE_OFFSET = 2'd3
    } cfg_reg_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [OBJ_INDEX_W-1:0] object_index;
        logic [OBJ_DIST_W-1:0]  object_distance;
        logic [WIDTH_DEG_W-1:0] width_deg;
        logic [ANGLE_W-1:0]     center_angle;
    } result_t;

endpackage

`default_nettype wire

[src/range_scan_object_segmenter_top.sv]
// ----------------------------------------------------------------------------
// range_scan_object_segmenter_top
// Splits one angular range sweep into objects and reports each object's
// center angle, angular width, midpoint distance and index in the sweep.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  s_tdata: distance; s_tlast: last sample
//  m_*       out   m_tvalid/m_tready  m_tdata: angle, width, distance, index
//  apb       in    psel/penable       four config registers at 4*i
//
//  One sample per cycle while the result register can load. A sample is held
//  in the input register, then the segment logic updates the run state and
//  loads the result register. Reset is synchronous, with no clearing pass. A
//  stalled result holds; one more sample is taken into the input register and
//  then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module range_scan_object_segmenter_top #(
    parameter int STEP_DEG  = 2,
    parameter int DIST_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // distance in [DIST_BITS-1:0], zero padded to whole bytes
    input  wire logic [((DIST_BITS+7)/8)*8-1:0]   s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // center_angle[8:0], width_deg[16:9], object_distance[32:17],
    // object_index[39:33]
    output logic [rsos_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rsos_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [rsos_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rsos_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    import rsos_pkg::*;

    localparam int CW          = ((DIST_BITS > MAX_DIST_W) ? DIST_BITS : MAX_DIST_W) + 2;
    localparam int LEFT_LIMIT  = EDGE_DEG / STEP_DEG;
    localparam int RIGHT_LIMIT = (SWEEP_DEG / STEP_DEG) - (EDGE_DEG / STEP_DEG);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAX_DIST_W-1:0]  max_dist_reg;
    logic [MIN_WIDTH_W-1:0] min_width_reg;
    logic [EDGE_TOL_W-1:0]  edge_tol_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic                   cfg_wr;
    cfg_reg_t               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg  <= MAX_DIST_RST;
            min_width_reg <= MIN_WIDTH_RST;
            edge_tol_reg  <= EDGE_TOL_RST;
            offset_reg    <= OFFSET_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_MAX_DISTANCE: max_dist_reg  <= pwdata[MAX_DIST_W-1:0];
                REG_MIN_WIDTH:    min_width_reg <= pwdata[MIN_WIDTH_W-1:0];
                REG_EDGE_TOL:     edge_tol_reg  <= pwdata[EDGE_TOL_W-1:0];
                REG_ANGLE_OFFSET: offset_reg    <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_MAX_DISTANCE: prdata = APB_DATA_W'(max_dist_reg);
            REG_MIN_WIDTH:    prdata = APB_DATA_W'(min_width_reg);
            REG_EDGE_TOL:     prdata = APB_DATA_W'(edge_tol_reg);
            REG_ANGLE_OFFSET: prdata = APB_DATA_W'(offset_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and result register handshake
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [DIST_BITS-1:0] in_dist_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic                 out_load;
    logic                 proc;
    logic                 s_beat;

    assign out_load = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_dist_reg <= s_tdata[DIST_BITS-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Run state and segment logic
    // ------------------------------------------------------------------
    logic [DIST_BITS-1:0]   run_min_reg, run_min_next;
    logic [DIST_BITS-1:0]   run_max_reg, run_max_next;
    logic [INDEX_W-1:0]     run_start_reg, run_start_next;
    logic [INDEX_W-1:0]     sample_index_reg, sample_index_next;
    logic                   seed_pending_reg, seed_pending_next;
    logic [OBJ_INDEX_W-1:0] object_count_reg, object_count_next;

    logic [CW-1:0]          d_x, min_x, max_x, tol_x, sum_x, lim_x;
    logic                   seeding, outside, close, pass, emit;
    logic [INDEX_W-1:0]     run_len;
    logic [INDEX_W:0]       run_end;
    logic [INDEX_W:0]       center_pos;
    logic [12:0]            ang_prod;
    logic [13:0]            ang_sum;
    logic [11:0]            width_prod;
    result_t                result;

    assign seeding = seed_pending_reg;
    assign d_x     = CW'(in_dist_reg);
    assign min_x   = CW'(run_min_reg);
    assign max_x   = CW'(run_max_reg);
    assign tol_x   = CW'(edge_tol_reg);
    assign lim_x   = CW'({max_dist_reg, 1'b0});
    assign outside = !seeding && ((d_x > max_x + tol_x) || (d_x + tol_x < min_x));
    assign close   = outside || (in_last_reg && sample_index_reg != '0);

    // a seeding sample that closes the sweep forms a run of its own value
    assign sum_x   = seeding ? (d_x + d_x) : (min_x + max_x);
    assign run_len = sample_index_reg - run_start_reg;
    assign run_end = {1'b0, run_start_reg} + {1'b0, run_len};

    // length >= floor(min_width / STEP_DEG) is (length + 1) * STEP_DEG > min_width
    assign pass = (13'(width_prod) + 13'(STEP_DEG) > 13'(min_width_reg))
               && (sum_x <= lim_x)
               && (run_start_reg > INDEX_W'(LEFT_LIMIT))
               && (run_end < (INDEX_W+1)'(RIGHT_LIMIT));
    assign emit = close && pass;

    assign center_pos = {1'b0, run_start_reg} + {2'b00, run_len[INDEX_W-1:1]};
    assign ang_prod   = 13'(center_pos * STEP_DEG);
    assign ang_sum    = {1'b0, ang_prod} + {{(14-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
    assign width_prod = 12'(run_len * STEP_DEG);

    always_comb begin
        result.center_angle    = ang_sum[ANGLE_W-1:0];
        result.width_deg       = (width_prod > 12'(WIDTH_DEG_MAX)) ? WIDTH_DEG_MAX
                                                                   : width_prod[WIDTH_DEG_W-1:0];
        result.object_distance = sum_x[OBJ_DIST_W:1];
        result.object_index    = object_count_reg;
    end

    always_comb begin
        run_min_next      = run_min_reg;
        run_max_next      = run_max_reg;
        run_start_next    = run_start_reg;
        sample_index_next = sample_index_reg;
        seed_pending_next = seed_pending_reg;
        object_count_next = object_count_reg;

        if (proc) begin
            if (seeding) begin
                run_min_next      = in_dist_reg;
                run_max_next      = in_dist_reg;
                seed_pending_next = 1'b0;
            end else if (!outside && !in_last_reg) begin
                if (in_dist_reg > run_max_reg) begin
                    run_max_next = in_dist_reg;
                end else if (in_dist_reg < run_min_reg) begin
                    run_min_next = in_dist_reg;
                end
            end

            if (emit && object_count_reg != OBJ_INDEX_MAX) begin
                object_count_next = object_count_reg + 1'b1;
            end

            // breaking sample starts the next run, the one after seeds it
            if (close && !in_last_reg) begin
                seed_pending_next = 1'b1;
                run_start_next    = sample_index_reg;
            end

            if (in_last_reg) begin
                run_min_next      = '0;
                run_max_next      = '0;
                run_start_next    = '0;
                sample_index_next = '0;
                seed_pending_next = 1'b1;
                object_count_next = '0;
            end else if (sample_index_reg != INDEX_MAX) begin
                sample_index_next = sample_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg      <= '0;
            run_max_reg      <= '0;
            run_start_reg    <= '0;
            sample_index_reg <= '0;
            seed_pending_reg <= 1'b1;
            object_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            run_min_reg      <= run_min_next;
            run_max_reg      <= run_max_next;
            run_start_reg    <= run_start_next;
            sample_index_reg <= sample_index_next;
            seed_pending_reg <= seed_pending_next;
            object_count_reg <= object_count_next;
            if (out_load) begin
                out_valid_reg <= proc && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_start_le_index: assert property (@(posedge aclk) disable iff (!aresetn)
        run_start_reg <= sample_index_reg)
        else $error("run start beyond sample index");

    a_sweep_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_last_reg |=> sample_index_reg == '0 && seed_pending_reg
                                && object_count_reg == '0)
        else $error("sweep state not cleared after last sample");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit && !in_last_reg && object_count_reg != OBJ_INDEX_MAX
        |=> object_count_reg == $past(object_count_reg) + 1'b1)
        else $error("object count did not advance");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |-> !s_tready)
        else $error("input taken while input register blocked");
`endif

endmodule

`default_nettype wire

[test/rsos_object_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsos_object_checker
// Watches the sample, object and register channels of the segmenter, tracks
// the run state of the sweep on its own, and compares every object beat
// against the next predicted object.
// ----------------------------------------------------------------------------

module rsos_object_checker #(
    parameter int STEP_DEG = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // distance[15:0]
    input  logic [rsos_pkg::MAX_DIST_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // center_angle[8:0], width_deg[16:9], object_distance[32:17],
    // object_index[39:33]
    input  logic [rsos_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsos_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rsos_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                             pready,
    output int                               fail_count,
    output int                               pending
);

    import rsos_pkg::*;

    localparam int LEFT_LIMIT  = EDGE_DEG / STEP_DEG;
    localparam int RIGHT_LIMIT = SWEEP_DEG / STEP_DEG - EDGE_DEG / STEP_DEG;

    logic [MAX_DIST_W-1:0]         max_dist;
    logic [MIN_WIDTH_W-1:0]        min_width;
    logic [EDGE_TOL_W-1:0]         edge_tol;
    logic signed [OFFSET_W-1:0]    ang_off;

    logic [MAX_DIST_W-1:0]         run_lo;
    logic [MAX_DIST_W-1:0]         run_hi;
    logic [INDEX_W-1:0]            run_first;
    logic [INDEX_W-1:0]            step_idx;
    logic                          seed_next;
    logic [OBJ_INDEX_W-1:0]        obj_count;

    result_t objects_due[$];
    result_t got;
    result_t want;
    result_t found;

    function automatic void start_sweep();
        run_lo    = '0;
        run_hi    = '0;
        run_first = '0;
        step_idx  = '0;
        seed_next = 1'b1;
        obj_count = '0;
    endfunction

    // Fold one sample into the run; return 1 when a closed run makes an object.
    function automatic bit segment_sample(input logic [MAX_DIST_W-1:0] d, input logic last,
                                          output result_t obj);
        logic                  seeding;
        logic                  outside;
        logic                  closing;
        logic                  emit;
        logic [INDEX_W-1:0]    len;
        logic [MAX_DIST_W:0]   sum;
        int                    ang;
        int                    wdeg;
        seeding = seed_next;
        outside = 1'b0;
        emit    = 1'b0;
        obj     = '0;
        if (seeding) begin
            run_lo    = d;
            run_hi    = d;
            seed_next = 1'b0;
        end else begin
            outside = (int'(d) > int'(run_hi) + int'(edge_tol)) ||
                      (int'(d) + int'(edge_tol) < int'(run_lo));
            // the closing last sample joins no range
            if (!outside && !last) begin
                if (d > run_hi)
                    run_hi = d;
                else if (d < run_lo)
                    run_lo = d;
            end
        end

        closing = (!seeding && outside) || (last && step_idx != '0);
        if (closing) begin
            len = step_idx - run_first;
            sum = {1'b0, run_lo} + {1'b0, run_hi};
            if (int'(len) >= int'(min_width) / STEP_DEG &&
                int'(sum) <= 2 * int'(max_dist) &&
                int'(run_first) > LEFT_LIMIT &&
                int'(run_first) + int'(len) < RIGHT_LIMIT) begin
                ang  = (int'(run_first) + int'(len) / 2) * STEP_DEG + int'(ang_off);
                wdeg = int'(len) * STEP_DEG;
                if (wdeg > int'(WIDTH_DEG_MAX))
                    wdeg = int'(WIDTH_DEG_MAX);
                obj.center_angle    = ang[ANGLE_W-1:0];
                obj.width_deg       = wdeg[WIDTH_DEG_W-1:0];
                obj.object_distance = sum[MAX_DIST_W:1];
                obj.object_index    = obj_count;
                if (obj_count < OBJ_INDEX_MAX)
                    obj_count++;
                emit = 1'b1;
            end
            // the breaking sample starts the next run, the one after it seeds
            if (!last) begin
                seed_next = 1'b1;
                run_first = step_idx;
            end
        end

        if (last)
            start_sweep();
        else if (step_idx < INDEX_MAX)
            step_idx++;
        return emit;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_dist   = MAX_DIST_RST;
            min_width  = MIN_WIDTH_RST;
            edge_tol   = EDGE_TOL_RST;
            ang_off    = OFFSET_RST;
            start_sweep();
            objects_due.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                // fields in order: angle/width/distance/index
                if (objects_due.size() == 0) begin
                    $display(
                        "%0t: unexpected object beat: actual %0d/%0d/%0d/%0d",
                        $time, $signed(got.center_angle), got.width_deg,
                        got.object_distance, got.object_index);
                    fail_count++;
                end else begin
                    want = objects_due.pop_front();
                    if (got.center_angle !== want.center_angle ||
                        got.width_deg !== want.width_deg ||
                        got.object_distance !== want.object_distance ||
                        got.object_index !== want.object_index) begin
                        $display(
                            "%0t: object mismatch: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                            $time, $signed(want.center_angle), want.width_deg,
                            want.object_distance, want.object_index,
                            $signed(got.center_angle), got.width_deg,
                            got.object_distance, got.object_index);
                        fail_count++;
                    end
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[APB_ADDR_W-1:2]))
                    REG_MAX_DISTANCE: max_dist  = pwdata[MAX_DIST_W-1:0];
                    REG_MIN_WIDTH:    min_width = pwdata[MIN_WIDTH_W-1:0];
                    REG_EDGE_TOL:     edge_tol  = pwdata[EDGE_TOL_W-1:0];
                    REG_ANGLE_OFFSET: ang_off   = pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                if (segment_sample(s_tdata, s_tlast, found))
                    objects_due.push_back(found);
            end
        end
        pending = objects_due.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives range sweeps into the object segmenter through several register
// settings and handshake patterns; the object checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
    import rsos_pkg::*;

    localparam int STEP_DEG      = 2;
    localparam int DIST_BITS     = 16;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [DIST_BITS-1:0]   s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     fail_count;
    int                     pending;
    int                     s_idle_pct  = 0;
    int                     m_stall_pct = 0;
    bit                     hold_armed  = 1'b0;
    bit                     hold_done   = 1'b0;
    int                     hold_cnt    = 0;
    int                     quiet_cycles = 0;
    int                     sent_count  = 0;
    logic [EDGE_TOL_W-1:0]  tol_now     = EDGE_TOL_RST;

    range_scan_object_segmenter_top #(
        .STEP_DEG  (STEP_DEG),
        .DIST_BITS (DIST_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rsos_object_checker #(
        .STEP_DEG (STEP_DEG)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 aclk = ~aclk;

    // Receiver: one long hold-off when armed, random stalls otherwise.
    always @(posedge aclk) begin
        if (hold_armed && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt == HOLD_CYCLES)
                hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
        end
    end

    // Watchdog: give up when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t r, input logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_sample(input logic [DIST_BITS-1:0] d, input logic last);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Wait out every predicted object, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One sweep built from flat segments with jumps between them, some noise.
    task automatic run_sweep(input bit long_one);
        int n;
        int seg_left;
        int base;
        int spread;
        int v;
        bit noisy;
        if (long_one)
            n = $urandom_range(260, 300);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(50, 100);
        noisy    = ($urandom_range(0, 7) == 0);
        seg_left = 0;
        base     = 0;
        spread   = 0;
        for (int i = 0; i < n; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 12);
                case ($urandom_range(0, 7))
                    0:       base = $urandom_range(0, 65535);
                    1:       base = $urandom_range(65000, 65535);
                    2:       base = $urandom_range(0, 300);
                    default: base = $urandom_range(300, 8000);
                endcase
                spread = $urandom_range(0, tol_now);
            end
            seg_left--;
            if (noisy && $urandom_range(0, 3) == 0)
                v = $urandom_range(0, 65535);
            else
                v = base + $urandom_range(0, spread);
            if (v > 65535)
                v = 65535;
            push_sample(v[DIST_BITS-1:0], i == n - 1);
        end
    endtask

    initial begin
        logic [MAX_DIST_W-1:0]      mx;
        logic [MIN_WIDTH_W-1:0]     mw;
        logic [EDGE_TOL_W-1:0]      tol;
        logic signed [OFFSET_W-1:0] off;
        idle_mode_t                 mode;
        bit                         pressure;
        bit                         long_one;
        int                         target;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // one-sample sweep: nothing comes out
        push_sample(16'd0, 1'b1);
        // run touching the left edge, full-scale run, closing last sample
        push_sample(16'd1000, 1'b0);
        push_sample(16'd1000, 1'b0);
        push_sample(16'd65535, 1'b0);
        push_sample(16'd65535, 1'b0);
        push_sample(16'd65535, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd100, 1'b0);
        push_sample(16'd50, 1'b1);
        // tolerance boundaries above and below the run
        push_sample(16'd5000, 1'b0);
        push_sample(16'd5160, 1'b0);
        push_sample(16'd4840, 1'b0);
        push_sample(16'd4679, 1'b0);
        push_sample(16'd4679, 1'b0);
        push_sample(16'd4679, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            pressure = 1'b0;
            long_one = 1'b0;
            case (p)
                0: begin mx = 16'hFFFF; mw = 8'd0;   tol = 16'd160;   off = -5;  mode = IDLE_NONE; end
                1: begin mx = 16'd4000; mw = 8'd10;  tol = 16'd100;   off = 15;  mode = IDLE_SENDER; end
                2: begin mx = 16'd0;    mw = 8'd0;   tol = 16'd0;     off = -16; mode = IDLE_RECEIVER; end
                3: begin mx = 16'hFFFF; mw = 8'd180; tol = 16'hFFFF;  off = 0;   mode = IDLE_BOTH; end
                4: begin
                    mx = 16'd30000; mw = 8'd4; tol = 16'd300; off = -1; mode = IDLE_NONE;
                    pressure = 1'b1;
                end
                5: begin
                    mx = 16'd8000; mw = 8'd255; tol = 16'd200; off = 7; mode = IDLE_NONE;
                    long_one = 1'b1;
                end
                6: begin mx = 16'hFFFF; mw = 8'd6;   tol = 16'd1;     off = -8;  mode = IDLE_SENDER; end
                default: begin
                    mx = 16'd12000; mw = 8'd2; tol = 16'd500; off = 3; mode = IDLE_BOTH;
                end
            endcase
            write_reg(REG_MAX_DISTANCE, {{(APB_DATA_W-MAX_DIST_W){1'b0}}, mx});
            write_reg(REG_MIN_WIDTH, {{(APB_DATA_W-MIN_WIDTH_W){1'b0}}, mw});
            write_reg(REG_EDGE_TOL, {{(APB_DATA_W-EDGE_TOL_W){1'b0}}, tol});
            write_reg(REG_ANGLE_OFFSET, {{(APB_DATA_W-OFFSET_W){1'b0}}, off});
            tol_now = tol;

            s_idle_pct  = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 7 : 0;
            m_stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 7 : 0;
            hold_armed  = pressure;

            target = sent_count + PHASE_ITEMS;
            run_sweep(long_one);
            while (sent_count < target)
                run_sweep(1'b0);
            drain();
            hold_armed = 1'b0;
        end

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
